// ----- hw/rtl/lfu_pkg.sv -----
// Shared types and constants for the LFU key-value table.
`default_nettype none

package lfu_pkg;

   localparam int unsigned KEY_W   = 31;
   localparam int unsigned VALUE_W = 31;
   localparam int unsigned COUNT_W = 32;
   localparam int unsigned CAP_W   = 5;

   localparam logic             KIND_GET  = 1'b0;
   localparam logic             KIND_PUT  = 1'b1;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef struct packed {
      logic               kind;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [VALUE_W-1:0] read_value;
      logic               evicted;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_SWEEP,
      ST_COMMIT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic start;
      logic step;
      logic sweep_mode;
      logic decide;
      logic commit;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic pass_done;
      logic need_sweep;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

// ----- hw/rtl/lfu_ctrl.sv -----
// Sequencer that steps the table datapath through scan, update and response.
`default_nettype none

module lfu_ctrl
   import lfu_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.pass_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = sts.need_sweep ? ST_SWEEP : ST_COMMIT;
         end
         ST_SWEEP: begin
            if (sts.pass_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.start = req_valid;
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
         end
         ST_SWEEP: begin
            cmd.step       = 1'b1;
            cmd.sweep_mode = 1'b1;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
         end
         ST_RESP: begin
            cmd.load_rsp = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hw/rtl/lfu_dpath.sv -----
// Entry memory, valid bits, scan registers and output register of the LFU table.
`default_nettype none

module lfu_dpath
   import lfu_pkg::*;
#(
   parameter int unsigned MAX_ENTRIES = 16
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [CAP_W-1:0] csr_data,
   input  wire cmd_type          cmd,
   output sts_type               sts
);

   localparam int unsigned IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int unsigned CNTW = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned RW   = IW;
   localparam int unsigned CMPW = (CNTW > CAP_W) ? CNTW : CAP_W;
   localparam logic [CNTW-1:0] LAST = CNTW'(MAX_ENTRIES);

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] data;
      logic [COUNT_W-1:0] count;
      logic [RW-1:0]      rank;
   } entry_type;

   entry_type mem [MAX_ENTRIES];

   // Control state.
   logic [CAP_W-1:0]       capacity_ff, capacity_in;
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [CNTW-1:0]        occ_ff, occ_in;
   logic [CNTW-1:0]        cnt_ff, cnt_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Payload state.
   req_type                req_ff, req_in;
   entry_type              rd_data_ff;
   logic [IW-1:0]          rd_idx_ff, rd_idx_in;
   logic                   match_found_ff, match_found_in;
   logic [IW-1:0]          match_idx_ff, match_idx_in;
   entry_type              match_ent_ff, match_ent_in;
   logic                   vic_any_ff, vic_any_in;
   logic [IW-1:0]          vic_idx_ff, vic_idx_in;
   logic [COUNT_W-1:0]     vic_count_ff, vic_count_in;
   logic [RW-1:0]          vic_rank_ff, vic_rank_in;
   logic                   free_found_ff, free_found_in;
   logic [IW-1:0]          free_idx_ff, free_idx_in;
   logic                   dec_hit_ff, dec_hit_in;
   logic                   dec_ins_ff, dec_ins_in;
   logic                   dec_ev_ff, dec_ev_in;
   logic [RW-1:0]          thr_ff, thr_in;
   logic [IW-1:0]          skip_idx_ff, skip_idx_in;
   logic [IW-1:0]          slot_ff, slot_in;
   rsp_type                res_ff, res_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic [IW-1:0]   rd_addr;
   logic            issue;
   logic            ent_v;
   logic            is_put;
   logic [CMPW-1:0] cap_ext;
   logic [CMPW-1:0] cap_eff;
   logic [CMPW-1:0] occ_ext;
   logic            hit_c;
   logic            ins_c;
   logic            ev_c;
   logic [CNTW-1:0] occ_m1;
   logic [CNTW-1:0] occ_base;
   logic            mem_we;
   logic [IW-1:0]   mem_waddr;
   entry_type       mem_wdata;

   assign rd_addr = cnt_ff[IW-1:0];
   assign issue   = cmd.step && (cnt_ff != LAST);
   assign ent_v   = valid_ff[rd_idx_ff];
   assign is_put  = (req_ff.kind == KIND_PUT);

   assign cap_ext = CMPW'(capacity_ff);
   assign cap_eff = (cap_ext > CMPW'(MAX_ENTRIES)) ? CMPW'(MAX_ENTRIES) : cap_ext;
   assign occ_ext = CMPW'(occ_ff);

   // A full table always holds a valid victim, since the capacity is nonzero.
   assign hit_c = match_found_ff;
   assign ins_c = !hit_c && is_put && (cap_eff != '0);
   assign ev_c  = ins_c && (occ_ext >= cap_eff);

   assign occ_m1   = occ_ff - CNTW'(1);
   assign occ_base = dec_ev_ff ? occ_m1 : occ_ff;

   assign sts.pass_done  = (cnt_ff == LAST) && !rd_vld_ff;
   assign sts.need_sweep = hit_c || ev_c;
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      capacity_in    = capacity_ff;
      valid_in       = valid_ff;
      occ_in         = occ_ff;
      cnt_in         = cnt_ff;
      rd_vld_in      = issue;
      rd_idx_in      = rd_addr;
      rsp_valid_in   = rsp_valid_ff;
      req_in         = req_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      match_ent_in   = match_ent_ff;
      vic_any_in     = vic_any_ff;
      vic_idx_in     = vic_idx_ff;
      vic_count_in   = vic_count_ff;
      vic_rank_in    = vic_rank_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      dec_hit_in     = dec_hit_ff;
      dec_ins_in     = dec_ins_ff;
      dec_ev_in      = dec_ev_ff;
      thr_in         = thr_ff;
      skip_idx_in    = skip_idx_ff;
      slot_in        = slot_ff;
      res_in         = res_ff;
      rsp_data_in    = rsp_data_ff;
      mem_we         = 1'b0;
      mem_waddr      = rd_idx_ff;
      mem_wdata      = rd_data_ff;

      if (csr_valid) begin
         capacity_in = csr_data;
      end

      if (issue) begin
         cnt_in = cnt_ff + CNTW'(1);
      end

      if (cmd.start) begin
         req_in         = req_data;
         cnt_in         = '0;
         match_found_in = 1'b0;
         vic_any_in     = 1'b0;
         free_found_in  = 1'b0;
      end

      // Scan: first key match, lowest count with oldest rank, first free slot.
      if (rd_vld_ff && !cmd.sweep_mode) begin
         if (ent_v && (rd_data_ff.key == req_ff.key) && !match_found_ff) begin
            match_found_in = 1'b1;
            match_idx_in   = rd_idx_ff;
            match_ent_in   = rd_data_ff;
         end
         if (ent_v && (!vic_any_ff || (rd_data_ff.count < vic_count_ff) ||
             ((rd_data_ff.count == vic_count_ff) && (rd_data_ff.rank < vic_rank_ff)))) begin
            vic_any_in   = 1'b1;
            vic_idx_in   = rd_idx_ff;
            vic_count_in = rd_data_ff.count;
            vic_rank_in  = rd_data_ff.rank;
         end
         if (!ent_v && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = rd_idx_ff;
         end
      end

      if (cmd.decide) begin
         cnt_in      = '0;
         dec_hit_in  = hit_c;
         dec_ins_in  = ins_c;
         dec_ev_in   = ev_c;
         thr_in      = hit_c ? match_ent_ff.rank : vic_rank_ff;
         skip_idx_in = hit_c ? match_idx_ff : vic_idx_ff;
         // The evicted slot is free too, so the lower of the two is used.
         if (ev_c && (!free_found_ff || (vic_idx_ff < free_idx_ff))) begin
            slot_in = vic_idx_ff;
         end else begin
            slot_in = free_idx_ff;
         end
         if (ev_c) begin
            valid_in[vic_idx_ff] = 1'b0;
         end
      end

      // Sweep: close the gap in the recency order left by the touched or evicted entry.
      if (rd_vld_ff && cmd.sweep_mode) begin
         if (ent_v && (rd_idx_ff != skip_idx_ff) && (rd_data_ff.rank > thr_ff)) begin
            mem_we         = 1'b1;
            mem_waddr      = rd_idx_ff;
            mem_wdata      = rd_data_ff;
            mem_wdata.rank = rd_data_ff.rank - RW'(1);
         end
      end

      if (cmd.commit) begin
         if (dec_hit_ff) begin
            mem_we          = 1'b1;
            mem_waddr       = match_idx_ff;
            mem_wdata.key   = match_ent_ff.key;
            mem_wdata.data  = is_put ? req_ff.value : match_ent_ff.data;
            mem_wdata.count = (match_ent_ff.count == '1) ? match_ent_ff.count
                                                         : match_ent_ff.count + COUNT_W'(1);
            mem_wdata.rank  = occ_m1[RW-1:0];
         end else if (dec_ins_ff) begin
            mem_we           = 1'b1;
            mem_waddr        = slot_ff;
            mem_wdata.key    = req_ff.key;
            mem_wdata.data   = req_ff.value;
            mem_wdata.count  = COUNT_W'(1);
            mem_wdata.rank   = occ_base[RW-1:0];
            valid_in[slot_ff] = 1'b1;
            occ_in           = occ_base + CNTW'(1);
         end
         res_in.hit        = dec_hit_ff;
         res_in.read_value = (dec_hit_ff && !is_put) ? match_ent_ff.data : '0;
         res_in.evicted    = dec_ev_ff;
      end

      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         valid_ff     <= '0;
         occ_ff       <= '0;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      rd_idx_ff      <= rd_idx_in;
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      match_ent_ff   <= match_ent_in;
      vic_any_ff     <= vic_any_in;
      vic_idx_ff     <= vic_idx_in;
      vic_count_ff   <= vic_count_in;
      vic_rank_ff    <= vic_rank_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      dec_hit_ff     <= dec_hit_in;
      dec_ins_ff     <= dec_ins_in;
      dec_ev_ff      <= dec_ev_in;
      thr_ff         <= thr_in;
      skip_idx_ff    <= skip_idx_in;
      slot_ff        <= slot_in;
      res_ff         <= res_in;
      rsp_data_ff    <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/lfu_cache_table_top.sv -----
// Top level of the LFU key-value table: controller plus datapath.
//
//   Channel  Direction  Handshake          Payload
//   req_     in         req_valid/stall    req_type  {kind, key, value}
//   rsp_     out        rsp_valid/stall    rsp_type  {hit, read_value, evicted}
//   csr_     in         csr_valid/ready    capacity (5 bits)
//
// One request is in flight at a time. A pass over the entry memory reads one entry
// per cycle; a hit or an eviction adds a second pass that renumbers the recency
// ranks. The next request can be taken in the same cycle that the response turns
// valid, even while that response waits under rsp_stall; the block then holds at
// its end until the output frees. Reset is synchronous and clears the valid bits
// at once.
`default_nettype none

module lfu_cache_table_top
   import lfu_pkg::*;
#(
   parameter int unsigned MAX_ENTRIES = 16
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [CAP_W-1:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   lfu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lfu_dpath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

`default_nettype wire
